[rtl/rsrt_pkg.sv]
// Shared types and constants for the register status rename table.
// No dependencies; compiled before every other file in rtl/.
`default_nettype none

package rsrt_pkg;

  // Default sizes handed to the top-level parameters
  localparam int NUM_REGS_DEF = 128;
  localparam int TAG_BITS_DEF = 16;

  // Fixed field widths on the streams
  localparam int REG_W      = 8;
  localparam int FIELD_W    = 17;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // Tag field pattern meaning "no producer"
  localparam logic [FIELD_W-1:0] NO_TAG = {FIELD_W{1'b1}};

  // Operation codes carried on in_tuser
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // input transfer: capture fields, launch table reads
    logic exec;  // update table and load the output register
  } cmd_t;

endpackage

`default_nettype wire

[rtl/rsrt_ctrl.sv]
// Handshake controller for the register status rename table.
// Depends on rsrt_pkg (cmd_t).
`default_nettype none

module rsrt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output rsrt_pkg::cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/rsrt_dp.sv]
// Datapath: status memory, per-entry valid bits, tag counter, result register.
// Depends on rsrt_pkg; driven by rsrt_ctrl commands.
`default_nettype none

module rsrt_dp #(
  parameter int NUM_REGS = rsrt_pkg::NUM_REGS_DEF,
  parameter int TAG_BITS = rsrt_pkg::TAG_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rsrt_pkg::cmd_t                   cmd,
  input  wire logic [rsrt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [rsrt_pkg::OP_W-1:0]        in_tuser,
  output logic      [rsrt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int FW    = rsrt_pkg::FIELD_W;
  localparam int RW    = rsrt_pkg::REG_W;

  // Entry: {ready, tag}; meaningful only while its valid bit is set
  logic [TAG_BITS:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0]   valid_r, valid_nxt;
  logic [TAG_BITS-1:0]   next_tag_r, next_tag_nxt;

  // Input decode
  logic [RW-1:0]    f_a, f_b, f_d;
  logic             ok_a, ok_b, ok_d;
  logic [IDX_W-1:0] idx_a, idx_b, idx_d, rd_addr_a;

  assign f_a = in_tdata[RW-1:0];
  assign f_b = in_tdata[2*RW-1:RW];
  assign f_d = in_tdata[3*RW-1:2*RW];

  assign ok_a  = !f_a[RW-1] && (32'(f_a[RW-2:0]) < NUM_REGS);
  assign ok_b  = !f_b[RW-1] && (32'(f_b[RW-2:0]) < NUM_REGS);
  assign ok_d  = !f_d[RW-1] && (32'(f_d[RW-2:0]) < NUM_REGS);
  assign idx_a = IDX_W'(f_a[RW-2:0]);
  assign idx_b = IDX_W'(f_b[RW-2:0]);
  assign idx_d = IDX_W'(f_d[RW-2:0]);

  // Port A serves the completing register on a completion
  assign rd_addr_a = (in_tuser == rsrt_pkg::OP_COMPLETE) ? idx_d : idx_a;

  // Captured item
  logic [rsrt_pkg::OP_W-1:0] op_r;
  logic                      ok_a_r, ok_b_r, ok_d_r;
  logic                      vld_a_r, vld_b_r;
  logic [IDX_W-1:0]          idx_d_r;
  logic [FW-1:0]             done_r;
  logic [TAG_BITS:0]         ent_a_r, ent_b_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      ok_a_r  <= ok_a;
      ok_b_r  <= ok_b;
      ok_d_r  <= ok_d;
      idx_d_r <= idx_d;
      done_r  <= in_tdata[3*RW+FW-1:3*RW];
      vld_a_r <= valid_r[rd_addr_a];
      vld_b_r <= valid_r[idx_b];
      ent_a_r <= mem[rd_addr_a];
      ent_b_r <= mem[idx_b];
    end
  end

  // Execute
  logic              hit_a, hit_b;
  logic [FW-1:0]     tag_a, tag_b, stored_d;
  logic              res_rdy_a, res_rdy_b;
  logic [FW-1:0]     res_tag_a, res_tag_b, res_dst;
  logic              mem_we;
  logic [TAG_BITS:0] mem_wdata;

  assign hit_a    = ok_a_r && vld_a_r;
  assign hit_b    = ok_b_r && vld_b_r;
  assign tag_a    = FW'(ent_a_r[TAG_BITS-1:0]);
  assign tag_b    = FW'(ent_b_r[TAG_BITS-1:0]);
  assign stored_d = vld_a_r ? tag_a : rsrt_pkg::NO_TAG;

  always_comb begin
    res_rdy_a    = 1'b1;
    res_tag_a    = rsrt_pkg::NO_TAG;
    res_rdy_b    = 1'b1;
    res_tag_b    = rsrt_pkg::NO_TAG;
    res_dst      = rsrt_pkg::NO_TAG;
    mem_we       = 1'b0;
    mem_wdata    = {1'b0, next_tag_r};
    valid_nxt    = valid_r;
    next_tag_nxt = next_tag_r;
    if (cmd.exec) begin
      case (op_r)
        rsrt_pkg::OP_DISPATCH: begin
          if (hit_a) begin
            res_rdy_a = ent_a_r[TAG_BITS];
            res_tag_a = tag_a;
          end
          if (hit_b) begin
            res_rdy_b = ent_b_r[TAG_BITS];
            res_tag_b = tag_b;
          end
          if (ok_d_r) begin
            mem_we             = 1'b1;
            mem_wdata          = {1'b0, next_tag_r};
            valid_nxt[idx_d_r] = 1'b1;
            res_dst            = FW'(next_tag_r);
            next_tag_nxt       = next_tag_r + 1'b1;
          end
        end
        rsrt_pkg::OP_COMPLETE: begin
          // Unwritten entries are already ready; only a live tag needs the write
          if (ok_d_r && vld_a_r && (stored_d == done_r)) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, ent_a_r[TAG_BITS-1:0]};
          end
        end
        rsrt_pkg::OP_FLUSH: begin
          valid_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_d_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      next_tag_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      next_tag_r <= next_tag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_tdata <= {3'b000, res_dst, res_tag_b, res_rdy_b, res_tag_a, res_rdy_a};
    end
  end

endmodule

`default_nettype wire

[rtl/register_status_rename_table.sv]
// Result: table read registered at the input transfer; table update and result
//   register load follow in the execute state, once the output slot is free.
// One item at a time (in_tready low in execute); the registered memory read and
//   the write-back of the same item are serialized on the one status memory.
// Reset (rst_n low, synchronous): every register reads ready with no producer,
//   tag counter cleared, both channels idle. Flush clears all entries at once.
`default_nettype none

module register_status_rename_table #(
  parameter int NUM_REGS = rsrt_pkg::NUM_REGS_DEF,
  parameter int TAG_BITS = rsrt_pkg::TAG_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input item
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // src_a_reg[7:0], src_b_reg[15:8], dst_reg[23:16], done_tag[40:24], zero pad
  input  wire logic [rsrt_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[1:0]: dispatch, completion, flush
  input  wire logic [rsrt_pkg::OP_W-1:0]        in_tuser,
  // Result item
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // src_a_ready[0], src_a_tag[17:1], src_b_ready[18], src_b_tag[35:19],
  // dst_tag[52:36], zero pad
  output logic      [rsrt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Controller owns the handshake and the output valid; the datapath owns
  // the table and the result payload. A new item may be taken while the
  // previous result still waits on out_tready.
  rsrt_pkg::cmd_t cmd;

  rsrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Status memory holds {ready, tag} per register; a valid bit per entry
  // stands in for the reset/flush value so a flush clears every entry at once.
  rsrt_dp #(
    .NUM_REGS (NUM_REGS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

[rtl/rsrt_checker.sv]
// Port-level checks for register_status_rename_table, bound to the top level.
// Depends on rsrt_pkg for stream widths.
`default_nettype none

module rsrt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rsrt_pkg::OUT_DATA_W-1:0] out_tdata
);

  // One item in flight: ready drops right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after an input transfer");

  // A new result only appears after the block has been busy working on an item
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without an item being processed");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind register_status_rename_table rsrt_checker u_rsrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
